### design/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// pcbp_pkg: shared types and constants of the prefix code bit packer
// Opcodes, fixed field widths and the control word passed from the table
// stage to the packing stage.
// ----------------------------------------------------------------------------
package pcbp_pkg;

   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int SYM_W            = 8;
   localparam int WORD_W           = 32;
   localparam int IN_LEN_W         = 6;
   localparam int BYTE_W           = 8;
   localparam int PAD_W            = 4;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } pcbp_op_type;

   typedef struct packed {
      logic valid;
      logic flush;
   } pcbp_stage_type;

endpackage

### design/pcbp_table.sv
// ----------------------------------------------------------------------------
// pcbp_table: command intake and code table
// Accepts commands, writes table entries on load, reads the entry of the
// symbol on encode and holds one encode or flush command for the packer.
// ----------------------------------------------------------------------------
module pcbp_table
   import pcbp_pkg::*;
#(
   parameter int CODE_W = WORD_W,
   parameter int LEN_W  = IN_LEN_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_opcode,
   input  logic [SYM_W-1:0]     req_symbol,
   input  logic [WORD_W-1:0]    req_code_bits,
   input  logic [IN_LEN_W-1:0]  req_code_length,
   input  logic                 take,
   output pcbp_stage_type       stage,
   output logic [CODE_W-1:0]    code_word,
   output logic [LEN_W-1:0]     code_len
);

   localparam int                ENTRY_W = CODE_W + LEN_W;
   localparam int                DEPTH   = 2 ** SYM_W;
   localparam logic [IN_LEN_W-1:0] CAP_LEN = IN_LEN_W'(CODE_W);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   pcbp_stage_type     stage_ff;
   pcbp_stage_type     stage_in;
   logic               accept;
   logic               is_load;
   logic [LEN_W-1:0]   len_sat;
   logic [CODE_W-1:0]  word_masked;

   assign busy    = stage_ff.valid && !take;
   assign accept  = start && !busy;
   assign len_sat = (req_code_length > CAP_LEN) ? LEN_W'(CODE_W)
                                                 : req_code_length[LEN_W-1:0];
   assign word_masked = req_code_bits[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_sat);

   always_comb begin
      stage_in = stage_ff;
      is_load  = 1'b0;
      if (accept) begin
         stage_in.valid = 1'b0;
         stage_in.flush = 1'b0;
         case (req_opcode)
            OP_LOAD: begin
               is_load = 1'b1;
            end
            OP_ENCODE: begin
               stage_in.valid = 1'b1;
            end
            OP_FLUSH: begin
               stage_in.valid = 1'b1;
               stage_in.flush = 1'b1;
            end
            default: begin
               stage_in.valid = 1'b0;
            end
         endcase
      end else if (take) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_load) begin
         mem[req_symbol] <= {len_sat, word_masked};
      end
      if (accept) begin
         rd_ff <= mem[req_symbol];
      end
   end

   assign stage     = stage_ff;
   assign code_word = rd_ff[CODE_W-1:0];
   assign code_len  = rd_ff[ENTRY_W-1:CODE_W];

endmodule

### design/pcbp_pack.sv
// ----------------------------------------------------------------------------
// pcbp_pack: bit accumulator and word output
// Appends code bits to the accumulator, sends one completed byte per cycle,
// pads the partial byte on flush and sends the padding count.
// ----------------------------------------------------------------------------
module pcbp_pack
   import pcbp_pkg::*;
#(
   parameter int CODE_W = WORD_W,
   parameter int LEN_W  = IN_LEN_W
) (
   input  logic               clock,
   input  logic               reset,
   input  pcbp_stage_type     stage,
   input  logic [CODE_W-1:0]  code_word,
   input  logic [LEN_W-1:0]   code_len,
   output logic               take,
   output logic               rsp_strobe,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_is_padding_count,
   output logic               rsp_last
);

   localparam int BUF_W = CODE_W + 7;
   localparam int CNT_W = $clog2(CODE_W + 16);
   localparam logic [CNT_W-1:0] ONE_BYTE = CNT_W'(BYTE_W);
   localparam logic [CNT_W-1:0] TWO_BYTE = CNT_W'(2 * BYTE_W);

   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pad_pend_ff, pad_pend_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic              strobe_ff, strobe_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              padflag_ff, padflag_in;
   logic              last_ff, last_in;
   logic              have_byte;
   logic [PAD_W-1:0]  pad_now;
   logic [BUF_W-1:0]  shifted;

   assign have_byte = cnt_ff >= ONE_BYTE;
   assign pad_now   = PAD_W'(BYTE_W) - {1'b0, cnt_ff[2:0]};
   assign shifted   = buf_ff >> (cnt_ff - ONE_BYTE);
   assign take      = stage.valid && !pad_pend_ff
                      && (stage.flush ? (cnt_ff < ONE_BYTE) : (cnt_ff < TWO_BYTE));

   always_comb begin
      buf_in      = buf_ff;
      cnt_in      = cnt_ff;
      pad_pend_in = pad_pend_ff;
      pad_in      = pad_ff;
      strobe_in   = 1'b0;
      byte_in     = byte_ff;
      padflag_in  = 1'b0;
      last_in     = 1'b0;
      if (pad_pend_ff) begin
         strobe_in   = 1'b1;
         byte_in     = BYTE_W'(pad_ff);
         padflag_in  = 1'b1;
         last_in     = 1'b1;
         pad_pend_in = 1'b0;
      end else if (have_byte) begin
         strobe_in = 1'b1;
         byte_in   = shifted[BYTE_W-1:0];
         last_in   = cnt_ff < TWO_BYTE;
         cnt_in    = cnt_ff - ONE_BYTE;
      end
      if (take && !stage.flush) begin
         buf_in = (buf_ff << code_len) | BUF_W'(code_word);
         cnt_in = cnt_in + CNT_W'(code_len);
      end
      if (take && stage.flush) begin
         strobe_in = 1'b1;
         cnt_in    = '0;
         if (cnt_ff[2:0] != 3'd0) begin
            byte_in     = BYTE_W'(buf_ff[BYTE_W-1:0] << pad_now);
            pad_pend_in = 1'b1;
            pad_in      = pad_now;
         end else begin
            byte_in    = BYTE_W'(pad_now);
            padflag_in = 1'b1;
            last_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         pad_pend_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         pad_pend_ff <= pad_pend_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff     <= buf_in;
      pad_ff     <= pad_in;
      byte_ff    <= byte_in;
      padflag_ff <= padflag_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_is_padding_count = padflag_ff;
   assign rsp_last             = last_ff;

endmodule

### design/prefix_code_bit_packer.sv
// ----------------------------------------------------------------------------
// prefix_code_bit_packer: prefix code encoder with byte packing
// Loads a per-symbol code table, packs symbol codes MSB first into bytes and
// pads and reports the padding count on flush.
// ----------------------------------------------------------------------------
// Results leave on rsp_strobe for one cycle each and cannot be held off, so
// the block paces itself through busy. A command is taken when start is high
// and busy low; load commands and encodes that complete no byte can be
// taken back to back. The output sends one word per cycle, so encodes that
// complete bytes can hold busy high while those bytes drain, and a flush
// sends two words when a partial byte remains, one otherwise. With the
// packer idle, the first byte of an encode passes through the table read
// register, the accumulator and the output register after it is taken.
// A flush goes from the table stage register straight to the output register.
module prefix_code_bit_packer
   import pcbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic [WORD_W-1:0]   req_code_bits,
   input  logic [IN_LEN_W-1:0] req_code_length,
   output logic                rsp_strobe,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_is_padding_count,
   output logic                rsp_last
);

   localparam int CODE_W = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
   localparam int LEN_W  = $clog2(CODE_W + 1);

   pcbp_stage_type    stage;
   logic              take;
   logic [CODE_W-1:0] code_word;
   logic [LEN_W-1:0]  code_len;

   pcbp_table #(
      .CODE_W (CODE_W),
      .LEN_W  (LEN_W)
   ) u_table (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .take            (take),
      .stage           (stage),
      .code_word       (code_word),
      .code_len        (code_len)
   );

   pcbp_pack #(
      .CODE_W (CODE_W),
      .LEN_W  (LEN_W)
   ) u_pack (
      .clock                (clock),
      .reset                (reset),
      .stage                (stage),
      .code_word            (code_word),
      .code_len             (code_len),
      .take                 (take),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_is_padding_count (rsp_is_padding_count),
      .rsp_last             (rsp_last)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the prefix code bit packer
// Drives load, encode, flush and undefined commands through the start/busy
// handshake, predicts the packed byte stream and padding counts in a
// scoreboard, and compares every strobed word field by field in order.
// A directed opening covers the corner cases. Random traffic follows in
// phases with and without sender idling.
// ----------------------------------------------------------------------------
module testbench
   import pcbp_pkg::*;
();

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         CODE_CAP     = (MAX_CODE_LEN_DEF < WORD_W) ?
                                         MAX_CODE_LEN_DEF : WORD_W;
   localparam int         RANDOM_ITEMS = 200;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         CYCLE_LIMIT  = 100000;
   localparam int         PRINT_LIMIT  = 50;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              is_pad;
      logic              is_last;
   } out_word_type;

   class packer_scoreboard;
      logic [WORD_W-1:0]   code_word_tbl [256];
      logic [IN_LEN_W-1:0] code_len_tbl [256];
      logic [BYTE_W-1:0]   acc_bits;
      int                  acc_count;
      out_word_type        expected_words [$];
      int                  mismatches;

      function new();
         acc_bits   = '0;
         acc_count  = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction

      function void take_command(logic [1:0] op, logic [SYM_W-1:0] sym,
                                 logic [WORD_W-1:0] bits, logic [IN_LEN_W-1:0] len);
         out_word_type fresh [$];
         out_word_type w;
         int           pad;
         if (op == OP_LOAD) begin
            code_word_tbl[sym] = bits;
            code_len_tbl[sym]  = (len > CODE_CAP) ? IN_LEN_W'(CODE_CAP) : len;
         end else if (op == OP_ENCODE) begin
            for (int i = code_len_tbl[sym]; i > 0; i--) begin
               acc_bits = {acc_bits[BYTE_W-2:0], code_word_tbl[sym][i-1]};
               acc_count++;
               if (acc_count == 8) begin
                  w.data    = acc_bits;
                  w.is_pad  = 1'b0;
                  w.is_last = 1'b0;
                  fresh.push_back(w);
                  acc_bits  = '0;
                  acc_count = 0;
               end
            end
            if (fresh.size() > 0) fresh[fresh.size()-1].is_last = 1'b1;
            foreach (fresh[k]) expected_words.push_back(fresh[k]);
         end else if (op == OP_FLUSH) begin
            pad = 8 - acc_count;
            if (acc_count != 0) begin
               w.data    = acc_bits << pad;
               w.is_pad  = 1'b0;
               w.is_last = 1'b0;
               expected_words.push_back(w);
            end
            w.data    = BYTE_W'(pad);
            w.is_pad  = 1'b1;
            w.is_last = 1'b1;
            expected_words.push_back(w);
            acc_bits  = '0;
            acc_count = 0;
         end
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_LIMIT) $display("%0t: MISMATCH %s", $realtime, msg);
         mismatches++;
      endtask

      task check_word(logic [BYTE_W-1:0] data, logic is_pad, logic is_last);
         out_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%02h pad=%0b last=%0b",
                                      data, is_pad, is_last));
            return;
         end
         want = expected_words.pop_front();
         if (data !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
         if (is_pad !== want.is_pad)
            report_mismatch($sformatf("is_padding_count %0b, want %0b", is_pad, want.is_pad));
         if (is_last !== want.is_last)
            report_mismatch($sformatf("last %0b, want %0b", is_last, want.is_last));
      endtask
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                start           = 1'b0;
   logic                busy;
   logic [1:0]          req_opcode      = '0;
   logic [SYM_W-1:0]    req_symbol      = '0;
   logic [WORD_W-1:0]   req_code_bits   = '0;
   logic [IN_LEN_W-1:0] req_code_length = '0;
   logic                rsp_strobe;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_is_padding_count;
   logic                rsp_last;

   packer_scoreboard    sb;
   bit                  sym_loaded [256];
   logic [SYM_W-1:0]    loaded_syms [$];
   int                  idle_pct;
   int                  random_sent;
   int                  cycle_count;

   prefix_code_bit_packer u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_symbol           (req_symbol),
      .req_code_bits        (req_code_bits),
      .req_code_length      (req_code_length),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_is_padding_count (rsp_is_padding_count),
      .rsp_last             (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.take_command(req_opcode, req_symbol, req_code_bits, req_code_length);
         if (rsp_strobe)
            sb.check_word(rsp_out_byte, rsp_is_padding_count, rsp_last);
      end
   end

   task send_command(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                     input logic [WORD_W-1:0] bits, input logic [IN_LEN_W-1:0] len);
      bit taken;
      taken = 1'b0;
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start           = 1'b1;
      req_opcode      = op;
      req_symbol      = sym;
      req_code_bits   = bits;
      req_code_length = len;
      if (op == OP_LOAD && !sym_loaded[sym]) begin
         sym_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      @(negedge clock);
   endtask

   task send_random_command;
      int                  pick;
      int                  len_pick;
      logic [IN_LEN_W-1:0] len;
      pick     = $urandom_range(99);
      len_pick = $urandom_range(99);
      if (len_pick < 60)      len = IN_LEN_W'($urandom_range(10, 1));
      else if (len_pick < 80) len = IN_LEN_W'($urandom_range(32, 11));
      else if (len_pick < 92) len = IN_LEN_W'($urandom_range(63, 33));
      else                    len = '0;
      if (pick < 15 || loaded_syms.size() == 0) begin
         send_command(OP_LOAD, SYM_W'($urandom_range(255)), $urandom, len);
         random_sent++;
      end else if (pick < 85) begin
         send_command(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                      $urandom, IN_LEN_W'($urandom_range(63)));
         random_sent++;
      end else if (pick < 95) begin
         send_command(OP_FLUSH, SYM_W'($urandom_range(255)), $urandom,
                      IN_LEN_W'($urandom_range(63)));
         random_sent++;
      end else begin
         send_command(OP_UNUSED, SYM_W'($urandom_range(255)), $urandom,
                      IN_LEN_W'($urandom_range(63)));
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int phase_pct [4];
      phase_pct   = '{0, 86, 0, 25};
      sb          = new();
      idle_pct    = 0;
      random_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_command(OP_FLUSH,  8'h00, 32'h0000_0000, 6'h00);
      send_command(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd0);
      send_command(OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
      send_command(OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32);
      send_command(OP_LOAD,   8'hA5, 32'hFFFF_FFF5, 6'd3);
      send_command(OP_LOAD,   8'h5A, 32'h8000_0001, 6'h3F);
      send_command(OP_LOAD,   8'h3C, 32'h1234_56C3, 6'd8);
      send_command(OP_ENCODE, 8'hA5, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'h3C, 32'hFFFF_FFFF, 6'h3F);
      send_command(OP_ENCODE, 8'hFF, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'h5A, 32'hFFFF_FFFF, 6'h3F);
      send_command(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_command(OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'h3F);
      send_command(OP_LOAD,   8'h01, 32'h0000_0001, 6'd1);
      send_command(OP_LOAD,   8'h02, 32'h0000_0000, 6'd7);
      send_command(OP_ENCODE, 8'h01, 32'h0000_0000, 6'h00);
      send_command(OP_FLUSH,  8'h00, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'h01, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'h02, 32'h0000_0000, 6'h00);
      send_command(OP_FLUSH,  8'h00, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'h02, 32'h0000_0000, 6'h00);
      send_command(OP_ENCODE, 8'hFF, 32'h0000_0000, 6'h00);
      send_command(OP_FLUSH,  8'h00, 32'h0000_0000, 6'h00);

      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_pct[p];
         while (random_sent < (p + 1) * RANDOM_ITEMS / 4) send_random_command();
      end
      start = 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
